@@ rtl/core/swrm_pkg.sv @@
package swrm_pkg;

  // ring depth in seconds, a power of two from 1 to 64
  localparam int WINDOW      = 8;
  localparam int BIN_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W       = $clog2(WINDOW + 1);

  localparam int DATA_W      = 32;
  localparam int BYTES_W     = 31;
  localparam int KBPS_W      = 22;
  localparam int KIB_SHIFT   = 10;
  localparam int STEP_W      = $clog2(DATA_W);

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 56;

  // item kinds carried on in_tuser
  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLEAR  = 7'b0000010,
    S_ADD_RD = 7'b0000100,
    S_ADD_WR = 7'b0001000,
    S_SUM    = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  // bin of a given second
  function automatic logic [BIN_W-1:0] bin_of(input logic [DATA_W-1:0] sec);
    return BIN_W'(sec % WINDOW);
  endfunction

endpackage

@@ rtl/core/sliding_window_rate_meter.sv @@
// Byte-throughput meter over a ring of per-second bins held in one small RAM.
// Input stream: in_tuser selects the kind of transaction (0 = byte arrival,
// 1 = rate query); in_tdata carries the current second and the byte count.
// An arrival gives no output; a query gives one output transaction with the
// average bytes per active second and the same figure in KiB per second.
// Sequence, one item at a time (in_tready is high only between items):
//   arrival: clears each bin that left the window (up to WINDOW) in turn, since the
//            single RAM write port serves clearing and the add, then adds to the current bin
//   query in the same second as the last computed one: straight to the output
//   other query: reads and sums all WINDOW bins, then the bit-serial divider
//            finds the average; the output waits until the output register is free
// The result sits in an output register, so a stalled receiver blocks nothing
// until a later query reaches S_RESP; arrivals carry on meanwhile.
// Reset (rst_n low, synchronous) empties the ring, zeroes the last seen
// second, the last query second and the cached rate, and drops any
// pending output. No clearing pass is needed after reset.
module sliding_window_rate_meter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [swrm_pkg::IN_TDATA_W-1:0]  in_tdata,   // now_second[31:0], byte_count[62:32]
  input  logic                             in_tuser,   // kind[0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [swrm_pkg::OUT_TDATA_W-1:0] out_tdata   // bytes_per_second[31:0],
                                                       // kbytes_per_second[53:32]
);
  import swrm_pkg::*;

  // bin storage
  logic [DATA_W-1:0] bin_mem [WINDOW];
  logic [WINDOW-1:0] bin_vld_r, bin_vld_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_ok_r;
  logic              mem_we;
  logic [BIN_W-1:0]  mem_wa, mem_ra;
  logic [DATA_W-1:0] mem_wd, rd_val;

  // control and payload registers
  state_t             state_r, state_nxt;
  logic [DATA_W-1:0]  newest_r, newest_nxt;
  logic [DATA_W-1:0]  query_sec_r, query_sec_nxt;
  logic [DATA_W-1:0]  cached_r, cached_nxt;
  logic [DATA_W-1:0]  now_r, now_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [BIN_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [DATA_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]   act_r, act_nxt;
  logic [DATA_W-1:0]  q_r, q_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   div_r, div_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_bps_r, out_bps_nxt;

  // datapath temporaries
  logic [DATA_W-1:0] in_now;
  logic [DATA_W-1:0] gap;
  logic [DATA_W:0]   add_wide;
  logic [DATA_W:0]   sum_wide;
  logic [DATA_W-1:0] sum_sat;
  logic [CNT_W-1:0]  act_new;
  logic [CNT_W:0]    trial;
  logic              qbit;

  assign in_now   = in_tdata[DATA_W-1:0];
  assign gap      = in_now - newest_r;
  assign rd_val   = rd_ok_r ? rd_data_r : '0;
  assign add_wide = {1'b0, rd_val} + (DATA_W+1)'(bytes_r);
  assign sum_wide = {1'b0, sum_r} + {1'b0, rd_val};
  assign sum_sat  = sum_wide[DATA_W] ? '1 : sum_wide[DATA_W-1:0];
  assign act_new  = (rd_val != '0) ? act_r + CNT_W'(1) : act_r;
  assign trial    = {rem_r, q_r[DATA_W-1]};
  assign qbit     = (trial >= {1'b0, div_r});

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-DATA_W-KBPS_W){1'b0}},
                       out_bps_r[DATA_W-1:KIB_SHIFT], out_bps_r};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    newest_nxt    = newest_r;
    query_sec_nxt = query_sec_r;
    cached_nxt    = cached_r;
    now_nxt       = now_r;
    bytes_nxt     = bytes_r;
    clr_idx_nxt   = clr_idx_r;
    clr_cnt_nxt   = clr_cnt_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = 1'b0;
    sum_nxt       = sum_r;
    act_nxt       = act_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_bps_nxt   = out_bps_r;
    mem_we        = 1'b0;
    mem_wa        = clr_idx_r;
    mem_wd        = '0;
    mem_ra        = cnt_r[BIN_W-1:0];

    // output transaction taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          now_nxt   = in_now;
          bytes_nxt = in_tdata[DATA_W+BYTES_W-1:DATA_W];
          if (in_tuser == KIND_ARRIVAL) begin
            newest_nxt = in_now;
            if (gap == '0) begin
              state_nxt = S_ADD_RD;
            end else begin
              clr_idx_nxt = bin_of(newest_r + DATA_W'(1));
              clr_cnt_nxt = (gap > DATA_W'(WINDOW)) ? CNT_W'(WINDOW) : gap[CNT_W-1:0];
              state_nxt   = S_CLEAR;
            end
          end else if (in_now == query_sec_r) begin
            state_nxt = S_RESP;
          end else begin
            query_sec_nxt = in_now;
            cnt_nxt       = '0;
            sum_nxt       = '0;
            act_nxt       = '0;
            state_nxt     = S_SUM;
          end
        end
      end

      // zero the bins that dropped out of the window
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_idx_r;
        clr_idx_nxt = BIN_W'((int'(clr_idx_r) + 1) % WINDOW);
        clr_cnt_nxt = clr_cnt_r - CNT_W'(1);
        if (clr_cnt_r == CNT_W'(1)) begin
          state_nxt = S_ADD_RD;
        end
      end

      S_ADD_RD: begin
        mem_ra    = bin_of(now_r);
        state_nxt = S_ADD_WR;
      end

      // saturating add into the current bin
      S_ADD_WR: begin
        mem_we    = 1'b1;
        mem_wa    = bin_of(now_r);
        mem_wd    = add_wide[DATA_W] ? '1 : add_wide[DATA_W-1:0];
        state_nxt = S_IDLE;
      end

      // stream all bins out of the ram, summing and counting active ones
      S_SUM: begin
        if (cnt_r < CNT_W'(WINDOW)) begin
          mem_ra      = cnt_r[BIN_W-1:0];
          rd_pend_nxt = 1'b1;
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
        if (rd_pend_r) begin
          sum_nxt = sum_sat;
          act_nxt = act_new;
          if (cnt_r == CNT_W'(WINDOW)) begin
            q_nxt     = sum_sat;
            rem_nxt   = '0;
            div_nxt   = (act_new == '0) ? CNT_W'(1) : act_new;
            step_nxt  = STEP_W'(DATA_W - 1);
            state_nxt = S_DIV;
          end
        end
      end

      // restoring divider, one quotient bit a cycle
      S_DIV: begin
        rem_nxt  = qbit ? CNT_W'(trial - {1'b0, div_r}) : trial[CNT_W-1:0];
        q_nxt    = {q_r[DATA_W-2:0], qbit};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          cached_nxt = {q_r[DATA_W-2:0], qbit};
          state_nxt  = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_bps_nxt   = cached_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // a bin never written since reset reads as zero
  always_comb begin
    bin_vld_nxt = bin_vld_r;
    if (mem_we) begin
      bin_vld_nxt[mem_wa] = 1'b1;
    end
  end

  // bin ram, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= bin_mem[mem_ra];
    rd_ok_r   <= bin_vld_r[mem_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bin_vld_r   <= '0;
      newest_r    <= '0;
      query_sec_r <= '0;
      cached_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bin_vld_r   <= bin_vld_nxt;
      newest_r    <= newest_nxt;
      query_sec_r <= query_sec_nxt;
      cached_r    <= cached_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    bytes_r   <= bytes_nxt;
    clr_idx_r <= clr_idx_nxt;
    clr_cnt_r <= clr_cnt_nxt;
    cnt_r     <= cnt_nxt;
    sum_r     <= sum_nxt;
    act_r     <= act_nxt;
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    step_r    <= step_nxt;
    out_bps_r <= out_bps_nxt;
  end

  // clearing never runs past one full turn of the ring
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> clr_cnt_r != '0 && clr_cnt_r <= CNT_W'(WINDOW))
    else $error("clear count out of range");

  // divider keeps a nonzero divisor and a remainder below it
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> div_r != '0 && rem_r < div_r)
    else $error("divider remainder not below divisor");

  // a repeat query in the same second goes straight to the response
  a_cached_query: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == KIND_QUERY && in_now == query_sec_r
    |=> state_r == S_RESP)
    else $error("cached query did not bypass the sum");

  // the last bin read of a sum is still pending when the count reaches WINDOW
  a_sum_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUM && cnt_r == CNT_W'(WINDOW) |-> rd_pend_r)
    else $error("sum finished without pending read");

endmodule
